/* src/two_line_pulse_deframer_macros.svh */
// Assertion helpers used by the framer source (tlpd_framer.sv).
`ifndef TWO_LINE_PULSE_DEFRAMER_MACROS_SVH
`define TWO_LINE_PULSE_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define TLPD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TLPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/tlpd_pkg.sv */
package tlpd_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int HIT_W        = 16;
   localparam int IDLE_W       = 17;
   localparam int LENGTH_W     = 16;
   localparam int ITEM_VALUE_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_HIT_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_LIMIT     = 1'b1;

   localparam logic [CSR_DATA_W-1:0] HIT_THRESHOLD_RESET = 16'd200;
   localparam logic [CSR_DATA_W-1:0] GAP_LIMIT_RESET     = 16'd100;

   localparam logic KIND_LENGTH = 1'b0;
   localparam logic KIND_DATA   = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT_LEN  = 2'd0,
      PH_LEN       = 2'd1,
      PH_HUNT_DATA = 2'd2,
      PH_DATA      = 2'd3
   } phase_type;

   typedef struct packed {
      logic fire;
      logic bit_val;
   } decision_type;

   typedef struct packed {
      logic                    valid;
      logic                    kind;
      logic [ITEM_VALUE_W-1:0] value;
      logic                    last;
   } item_type;

endpackage

/* src/tlpd_req_if.sv */
interface tlpd_req_if;
   logic                          valid;
   logic                          ready;
   logic [tlpd_pkg::SAMPLE_W-1:0] latency_line_one;
   logic [tlpd_pkg::SAMPLE_W-1:0] latency_line_zero;

   modport source (output valid, output latency_line_one, output latency_line_zero,
                   input ready);
   modport sink (input valid, input latency_line_one, input latency_line_zero,
                 output ready);
endinterface

/* src/tlpd_rsp_if.sv */
interface tlpd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              item_kind;
   logic [tlpd_pkg::ITEM_VALUE_W-1:0] item_value;
   logic                              is_last;

   modport source (output valid, output item_kind, output item_value, output is_last,
                   input ready);
   modport sink (input valid, input item_kind, input item_value, input is_last,
                 output ready);
endinterface

/* src/two_line_pulse_deframer.sv */
// Pipeline: a poll passes the input register (s1), then the result register that drives rsp.
// Throughput: one poll per cycle unless rsp stalls; the input register and the result register
// let a new poll enter while a finished result waits on rsp.
// Reset (synchronous, active high): registers return to 200 and 100, hit and idle
// counts clear, and the framer starts hunting for a message start.
module two_line_pulse_deframer #(
   parameter int FRAME_BITS  = 40,
   parameter int LENGTH_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   tlpd_req_if.sink                         req,
   tlpd_rsp_if.source                       rsp,
   input  logic                             csr_write_en,
   input  logic [tlpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tlpd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import tlpd_pkg::*;

   logic [CSR_DATA_W-1:0]   threshold_ff, threshold_in;
   logic [CSR_DATA_W-1:0]   gap_ff, gap_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic [SAMPLE_W-1:0]     s1_one_ff, s1_one_in;
   logic [SAMPLE_W-1:0]     s1_zero_ff, s1_zero_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [ITEM_VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    advance, req_ready;
   decision_type            decision;
   item_type                item;

   always_comb begin
      threshold_in = threshold_ff;
      gap_in       = gap_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_HIT_THRESHOLD: threshold_in = csr_write_data;
            CSR_GAP_LIMIT:     gap_in       = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // the poll in s1 moves on once the result register is free or being emptied
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req.ready = req_ready;

   assign s1_valid_in = req_ready ? req.valid : s1_valid_ff;
   assign s1_one_in   = (req_ready && req.valid) ? req.latency_line_one : s1_one_ff;
   assign s1_zero_in  = (req_ready && req.valid) ? req.latency_line_zero : s1_zero_ff;

   tlpd_bit_slicer u_slicer (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .latency_one   (s1_one_ff),
      .latency_zero  (s1_zero_ff),
      .hit_threshold (threshold_ff),
      .gap_limit     (gap_ff),
      .decision      (decision)
   );

   tlpd_framer #(
      .FRAME_BITS  (FRAME_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_framer (
      .clock (clock),
      .reset (reset),
      .dec   (decision),
      .res   (item)
   );

   assign rsp_valid_in = advance ? item.valid : (rsp_valid_ff && !rsp.ready);
   assign rsp_kind_in  = (advance && item.valid) ? item.kind  : rsp_kind_ff;
   assign rsp_value_in = (advance && item.valid) ? item.value : rsp_value_ff;
   assign rsp_last_in  = (advance && item.valid) ? item.last  : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= HIT_THRESHOLD_RESET;
         gap_ff       <= GAP_LIMIT_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         gap_ff       <= gap_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_one_ff    <= s1_one_in;
      s1_zero_ff   <= s1_zero_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.item_kind  = rsp_kind_ff;
   assign rsp.item_value = rsp_value_ff;
   assign rsp.is_last    = rsp_last_ff;

endmodule

/* src/tlpd_bit_slicer.sv */
module tlpd_bit_slicer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic [tlpd_pkg::SAMPLE_W-1:0] latency_one,
   input  logic [tlpd_pkg::SAMPLE_W-1:0] latency_zero,
   input  logic [tlpd_pkg::SAMPLE_W-1:0] hit_threshold,
   input  logic [tlpd_pkg::SAMPLE_W-1:0] gap_limit,
   output tlpd_pkg::decision_type        decision
);
   import tlpd_pkg::*;

   logic [HIT_W-1:0]  ones_ff, ones_in;
   logic [HIT_W-1:0]  zeros_ff, zeros_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;
   logic              hit_one, hit_zero, decide;

   assign hit_one  = latency_one < hit_threshold;
   assign hit_zero = latency_zero < hit_threshold;
   // a hit on either line blocks a decision on the same poll and restarts the idle count at one
   assign decide   = !hit_one && !hit_zero && (idle_ff > {1'b0, gap_limit});

   assign decision.fire    = enable && decide;
   assign decision.bit_val = ones_ff > zeros_ff;

   always_comb begin
      ones_in  = ones_ff;
      zeros_in = zeros_ff;
      idle_in  = idle_ff;
      if (enable) begin
         if (decide) begin
            ones_in  = '0;
            zeros_in = '0;
            idle_in  = '0;
         end else begin
            if (hit_one && ones_ff != '1) begin
               ones_in = ones_ff + 1'b1;
            end
            if (hit_zero && zeros_ff != '1) begin
               zeros_in = zeros_ff + 1'b1;
            end
            if (hit_one || hit_zero) begin
               idle_in = IDLE_W'(1);
            end else if (idle_ff != '1) begin
               idle_in = idle_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_ff  <= '0;
         zeros_ff <= '0;
         idle_ff  <= '0;
      end else begin
         ones_ff  <= ones_in;
         zeros_ff <= zeros_in;
         idle_ff  <= idle_in;
      end
   end

endmodule

/* src/tlpd_framer.sv */
`include "two_line_pulse_deframer_macros.svh"

module tlpd_framer #(
   parameter int FRAME_BITS  = 40,
   parameter int LENGTH_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tlpd_pkg::decision_type dec,
   output tlpd_pkg::item_type     res
);
   import tlpd_pkg::*;

   localparam int FRAME_CNT_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
   localparam logic [FRAME_CNT_W-1:0] FRAME_LAST = FRAME_CNT_W'(FRAME_BITS - 1);
   localparam logic [LENGTH_W:0]      LEN_DONE   = (LENGTH_W + 1)'(LENGTH_BITS);

   phase_type               phase_ff, phase_in;
   logic                    hunt_last_ff, hunt_last_in;
   logic                    armed_ff, armed_in;
   logic [LENGTH_W-1:0]     length_ff, length_in;
   logic [LENGTH_W-1:0]     count_ff, count_in;
   logic [FRAME_CNT_W-1:0]  frame_ff, frame_in;

   logic                    hunt_done, armed_now, last_bit;
   logic [LENGTH_W:0]       count_inc;
   logic [LENGTH_W-1:0]     shifted;

   // 1 then 0 arms the hunt; a later 1,1 pair completes it
   assign armed_now = armed_ff | (hunt_last_ff & ~dec.bit_val);
   assign hunt_done = armed_ff & hunt_last_ff & dec.bit_val;
   assign count_inc = {1'b0, count_ff} + 1'b1;
   assign shifted   = {length_ff[LENGTH_W-2:0], dec.bit_val};
   assign last_bit  = count_inc >= {1'b0, length_ff};

   always_comb begin
      phase_in     = phase_ff;
      hunt_last_in = hunt_last_ff;
      armed_in     = armed_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      frame_in     = frame_ff;
      res          = '0;
      if (dec.fire) begin
         case (phase_ff)
            PH_HUNT_LEN: begin
               if (hunt_done) begin
                  hunt_last_in = 1'b0;
                  armed_in     = 1'b0;
                  phase_in     = PH_LEN;
                  length_in    = '0;
                  count_in     = '0;
               end else begin
                  hunt_last_in = dec.bit_val;
                  armed_in     = armed_now;
               end
            end
            PH_LEN: begin
               length_in = shifted;
               if (count_inc < LEN_DONE) begin
                  count_in = count_inc[LENGTH_W-1:0];
               end else begin
                  count_in     = '0;
                  frame_in     = '0;
                  hunt_last_in = 1'b0;
                  armed_in     = 1'b0;
                  res.valid    = 1'b1;
                  res.kind     = KIND_LENGTH;
                  res.value    = shifted;
                  phase_in     = (shifted == '0) ? PH_HUNT_LEN : PH_HUNT_DATA;
               end
            end
            PH_HUNT_DATA: begin
               if (hunt_done) begin
                  hunt_last_in = 1'b0;
                  armed_in     = 1'b0;
                  phase_in     = PH_DATA;
               end else begin
                  hunt_last_in = dec.bit_val;
                  armed_in     = armed_now;
               end
            end
            PH_DATA: begin
               res.valid = 1'b1;
               res.kind  = KIND_DATA;
               res.value = ITEM_VALUE_W'(dec.bit_val);
               res.last  = last_bit;
               if (last_bit) begin
                  count_in     = '0;
                  length_in    = '0;
                  hunt_last_in = 1'b0;
                  armed_in     = 1'b0;
                  phase_in     = PH_HUNT_LEN;
               end else begin
                  count_in = count_inc[LENGTH_W-1:0];
                  // re-hunt at every frame boundary of the data bits
                  if (frame_ff == FRAME_LAST) begin
                     frame_in     = '0;
                     hunt_last_in = 1'b0;
                     armed_in     = 1'b0;
                     phase_in     = PH_HUNT_DATA;
                  end else begin
                     frame_in = frame_ff + 1'b1;
                  end
               end
            end
            default: begin
               phase_in = PH_HUNT_LEN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT_LEN;
         hunt_last_ff <= 1'b0;
         armed_ff     <= 1'b0;
         length_ff    <= '0;
         count_ff     <= '0;
         frame_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         hunt_last_ff <= hunt_last_in;
         armed_ff     <= armed_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         frame_ff     <= frame_in;
      end
   end

   `TLPD_ASSERT_IMPLIES(a_result_needs_bit, clock, reset, res.valid, dec.fire,
      "result without a decided bit")
   `TLPD_ASSERT_NEXT(a_length_then_hunt, clock, reset, res.valid && res.kind == KIND_LENGTH,
      phase_ff == PH_HUNT_LEN || phase_ff == PH_HUNT_DATA, "no hunt after length word")
   `TLPD_ASSERT_NEXT(a_last_restarts, clock, reset, res.valid && res.last,
      phase_ff == PH_HUNT_LEN && count_ff == '0, "message end did not restart hunt")

endmodule
